@@ hdl/plc_pkg.sv @@
// shared types, constants and helpers for the pointer controller link
// no dependencies; imported by every module of the block
package plc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADZONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DPAD_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID       = 3'd5;

    localparam logic [9:0] RST_CONNECT_DELAY   = 10'd100;
    localparam logic [7:0] RST_PACKET_INTERVAL = 8'd25;
    localparam logic [6:0] RST_STICK_DEADZONE  = 7'd12;
    localparam logic [2:0] RST_STICK_SHIFT     = 3'd2;
    localparam logic [6:0] RST_DPAD_SPEED      = 7'd32;
    localparam logic [6:0] RST_DEVICE_ID       = 7'd77;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;

    localparam logic [9:0] CONNECT_MAX = 10'd1023;
    localparam logic [7:0] PACKET_MAX  = 8'd255;

    // one job for the back end: an id word alone, or a three-word packet
    typedef struct packed {
        logic       single;
        logic [6:0] b0;
        logic [6:0] b1;
        logic [6:0] b2;
    } t_job;

    function automatic logic [6:0] line_of(input logic [7:0] b);
        return ~b[6:0];
    endfunction

endpackage

@@ hdl/plc_front.sv @@
// front end: link mode tracking, tick counters, motion and packet build
// depends on plc_pkg; feeds jobs into plc_queue
module plc_front import plc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_ready_line,
    input  logic                  i_input_present,
    input  logic [7:0]            i_stick_x,
    input  logic [7:0]            i_stick_y,
    input  logic                  i_pad_left,
    input  logic                  i_pad_right,
    input  logic                  i_pad_up,
    input  logic                  i_pad_down,
    input  logic                  i_first_button,
    input  logic                  i_second_button,
    output logic                  o_job_push,
    output t_job                  o_job,
    input  logic                  i_job_full
);

    logic [9:0] r_connect_delay;
    logic [7:0] r_packet_interval;
    logic [6:0] r_stick_deadzone;
    logic [2:0] r_stick_shift;
    logic [6:0] r_dpad_speed;
    logic [6:0] r_device_id;

    logic [1:0] r_mode, n_mode;
    logic [9:0] r_connect_elapsed, n_connect_elapsed;
    logic [7:0] r_packet_elapsed, n_packet_elapsed;

    logic       accept;
    logic [9:0] connect_inc;
    logic [7:0] packet_inc;
    logic [7:0] dx, dy;
    logic [7:0] b0;

    function automatic logic [7:0] stick_motion(input logic [7:0] pos,
                                                input logic [6:0] dz,
                                                input logic [2:0] sh);
        logic [7:0] mag;
        logic [7:0] d;
        // below 128 the centred value is negative
        mag = pos[7] ? {1'b0, pos[6:0]} : (8'd128 - pos);
        if (mag < {1'b0, dz}) begin
            return 8'd0;
        end
        d = mag >> sh;
        if (d > 8'd127) begin
            d = 8'd127;
        end
        return pos[7] ? d : (8'd0 - d);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connect_delay   <= RST_CONNECT_DELAY;
            r_packet_interval <= RST_PACKET_INTERVAL;
            r_stick_deadzone  <= RST_STICK_DEADZONE;
            r_stick_shift     <= RST_STICK_SHIFT;
            r_dpad_speed      <= RST_DPAD_SPEED;
            r_device_id       <= RST_DEVICE_ID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CONNECT_DELAY:   r_connect_delay   <= i_cfg_data;
                CFG_PACKET_INTERVAL: r_packet_interval <= i_cfg_data[7:0];
                CFG_STICK_DEADZONE:  r_stick_deadzone  <= i_cfg_data[6:0];
                CFG_STICK_SHIFT:     r_stick_shift     <= i_cfg_data[2:0];
                CFG_DPAD_SPEED:      r_dpad_speed      <= i_cfg_data[6:0];
                CFG_DEVICE_ID:       r_device_id       <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_full = i_job_full;
    assign accept = i_push && !i_job_full;

    assign connect_inc = (r_connect_elapsed == CONNECT_MAX) ? r_connect_elapsed
                                                            : r_connect_elapsed + 10'd1;
    assign packet_inc  = (r_packet_elapsed == PACKET_MAX) ? r_packet_elapsed
                                                          : r_packet_elapsed + 8'd1;

    always_comb begin
        dx = 8'd0;
        dy = 8'd0;
        b0 = 8'hC0;
        if (i_input_present) begin
            priority if (i_pad_right) dx = {1'b0, r_dpad_speed};
            else if (i_pad_left)      dx = 8'd0 - {1'b0, r_dpad_speed};
            else                      dx = stick_motion(i_stick_x, r_stick_deadzone,
                                                        r_stick_shift);
            priority if (i_pad_down)  dy = {1'b0, r_dpad_speed};
            else if (i_pad_up)        dy = 8'd0 - {1'b0, r_dpad_speed};
            else                      dy = stick_motion(i_stick_y, r_stick_deadzone,
                                                        r_stick_shift);
            b0[5] = i_first_button;
            b0[4] = i_second_button;
        end
        b0[3:2] = dy[7:6];
        b0[1:0] = dx[7:6];
    end

    always_comb begin
        n_mode            = r_mode;
        n_connect_elapsed = r_connect_elapsed;
        n_packet_elapsed  = r_packet_elapsed;
        o_job_push        = 1'b0;
        o_job.single      = 1'b1;
        o_job.b0          = line_of({1'b0, r_device_id});
        o_job.b1          = line_of({2'b10, dx[5:0]});
        o_job.b2          = line_of({2'b10, dy[5:0]});
        if (accept) begin
            unique case (r_mode)
                MODE_WAIT: begin
                    if (!i_ready_line) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_connect_elapsed = connect_inc;
                        if (connect_inc >= r_connect_delay) begin
                            n_mode           = MODE_STREAM;
                            n_packet_elapsed = 8'd0;
                            o_job_push       = 1'b1;
                        end
                    end
                end
                MODE_STREAM: begin
                    if (!i_ready_line) begin
                        n_mode = MODE_IDLE;
                    end else if (packet_inc < r_packet_interval) begin
                        n_packet_elapsed = packet_inc;
                    end else begin
                        n_packet_elapsed = 8'd0;
                        o_job_push       = 1'b1;
                        o_job.single     = 1'b0;
                        o_job.b0         = line_of(b0);
                    end
                end
                default: begin
                    // idle, and the unused code behaves as idle
                    n_mode = MODE_IDLE;
                    if (i_ready_line) begin
                        n_mode            = MODE_WAIT;
                        n_connect_elapsed = 10'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_IDLE;
            r_connect_elapsed <= 10'd0;
            r_packet_elapsed  <= 8'd0;
        end else begin
            r_mode            <= n_mode;
            r_connect_elapsed <= n_connect_elapsed;
            r_packet_elapsed  <= n_packet_elapsed;
        end
    end

    a_id_enters_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_push && o_job.single) |=> (r_mode == MODE_STREAM && r_packet_elapsed == 8'd0))
        else $error("id word not followed by streaming mode");

    a_packet_only_streaming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_push && !o_job.single) |-> (r_mode == MODE_STREAM && i_ready_line))
        else $error("packet built outside streaming mode");

    a_drop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_ready_line) |=> (r_mode == MODE_IDLE))
        else $error("ready low did not return the link to idle");

endmodule

@@ hdl/plc_queue.sv @@
// short job queue between the front and back ends
// depends on plc_pkg for the job type
module plc_queue import plc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("front pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("back popped an empty queue");

endmodule

@@ hdl/plc_back.sv @@
// back end: holds one job and hands its words out one per pop
// depends on plc_pkg; pulls jobs from plc_queue
module plc_back import plc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_empty,
    output logic       o_job_pop,
    output logic [6:0] o_line_byte,
    output logic       o_last_byte,
    output logic       o_empty,
    input  logic       i_pop
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    t_job       r_job;
    logic       taken;
    logic       last;

    assign o_empty = !r_valid;
    assign taken   = i_pop && r_valid;
    assign last    = r_job.single || (r_idx == 2'd2);

    always_comb begin
        unique case (r_idx)
            2'd1:    o_line_byte = r_job.b1;
            2'd2:    o_line_byte = r_job.b2;
            default: o_line_byte = r_job.b0;
        endcase
    end
    assign o_last_byte = last;

    always_comb begin
        n_valid   = r_valid;
        n_idx     = r_idx;
        o_job_pop = 1'b0;
        // reload from the queue when idle or when the last word leaves
        if (!r_valid || (taken && last)) begin
            n_idx     = 2'd0;
            n_valid   = !i_job_empty;
            o_job_pop = !i_job_empty;
        end else if (taken) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx != 2'd3 && (!r_job.single || r_idx == 2'd0)))
        else $error("word index out of range for job");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_idx)))
        else $error("word changed while stalled");

    a_load_starts_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_valid && r_idx == 2'd0))
        else $error("loaded job does not start at its first word");

endmodule

@@ hdl/pointer_controller_link.sv @@
// top level of the pointer controller link
// depends on plc_pkg, plc_front, plc_queue and plc_back
//
// channel   direction  handshake              payload
// tick      in         push / full            i_ready_line .. i_second_button
// word      out        empty / pop            o_line_byte, o_last_byte
// config    in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// a tick is taken by the front end every cycle unless the job queue is full;
// a tick causes zero, one or three words
// the back end hands out one word per cycle while pop is held and a job is waiting;
// the front end keeps taking ticks while earlier words are still handed out
// reset (i_rst_n low, synchronous) returns the link to idle and the registers
// to their defaults; full rises only when the queue holds QDEPTH jobs
module pointer_controller_link import plc_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_ready_line,
    input  logic                  i_input_present,
    input  logic [7:0]            i_stick_x,
    input  logic [7:0]            i_stick_y,
    input  logic                  i_pad_left,
    input  logic                  i_pad_right,
    input  logic                  i_pad_up,
    input  logic                  i_pad_down,
    input  logic                  i_first_button,
    input  logic                  i_second_button,
    output logic                  empty,
    input  logic                  pop,
    output logic [6:0]            o_line_byte,
    output logic                  o_last_byte
);

    logic job_push, job_full, job_pop, job_empty;
    t_job job_in, job_out;

    plc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .o_full          (full),
        .i_ready_line    (i_ready_line),
        .i_input_present (i_input_present),
        .i_stick_x       (i_stick_x),
        .i_stick_y       (i_stick_y),
        .i_pad_left      (i_pad_left),
        .i_pad_right     (i_pad_right),
        .i_pad_up        (i_pad_up),
        .i_pad_down      (i_pad_down),
        .i_first_button  (i_first_button),
        .i_second_button (i_second_button),
        .o_job_push      (job_push),
        .o_job           (job_in),
        .i_job_full      (job_full)
    );

    plc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    plc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_line_byte (o_line_byte),
        .o_last_byte (o_last_byte),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
